### design/spq_pkg.sv
`default_nettype none

package spq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int KEY_BITS  = 24;
    localparam int TAG_BITS  = 16;
    localparam int CAP_W     = 5;
    localparam int OCC_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } spq_status_t;

    typedef struct packed {
        logic                req_type;
        logic [KEY_BITS-1:0] entry_key;
        logic [TAG_BITS-1:0] entry_tag;
    } spq_req_t;

    typedef struct packed {
        spq_status_t         status;
        logic [KEY_BITS-1:0] out_key;
        logic [TAG_BITS-1:0] out_tag;
        logic [OCC_W-1:0]    occupancy;
        logic                is_empty;
        logic                is_full;
    } spq_rsp_t;

    // Shift command broadcast to every cell
    typedef struct packed {
        logic                insert;
        logic                remove;
        logic [KEY_BITS-1:0] key;
        logic [TAG_BITS-1:0] tag;
    } spq_cmd_t;

endpackage

`default_nettype wire

### design/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic                aclk,
    input  wire spq_cmd_t            cmd,
    input  wire logic                occupied,
    input  wire logic                left_le,
    input  wire logic [KEY_BITS-1:0] left_key,
    input  wire logic [TAG_BITS-1:0] left_tag,
    input  wire logic [KEY_BITS-1:0] right_key,
    input  wire logic [TAG_BITS-1:0] right_tag,
    output logic                     le,
    output logic [KEY_BITS-1:0]      key,
    output logic [TAG_BITS-1:0]      tag
);

    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [TAG_BITS-1:0] tag_reg, tag_next;

    // Entry stays in place on insert when it sorts at or before the new key
    assign le  = occupied && (key_reg <= cmd.key);
    assign key = key_reg;
    assign tag = tag_reg;

    always_comb begin
        key_next = key_reg;
        tag_next = tag_reg;
        if (cmd.insert) begin
            if (!le) begin
                if (left_le) begin
                    key_next = cmd.key;
                    tag_next = cmd.tag;
                end else begin
                    key_next = left_key;
                    tag_next = left_tag;
                end
            end
        end else if (cmd.remove) begin
            key_next = right_key;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire

### design/sorted_priority_queue.sv
// Sorted priority queue, smallest key first, built as a row of shift cells.
// Input channel s_valid/s_ready/s_data carries one request per beat: an
// insert of a key and tag, or a remove of the smallest-key entry. Equal keys
// leave in arrival order. Every request yields exactly one result beat on
// m_valid/m_ready/m_data with status, removed key and tag, occupancy, empty
// and full flags. A rejected request (insert while full, remove while empty)
// changes nothing.
// m_valid rises in the cycle after acceptance. All cells compare against
// the broadcast key and shift in the same cycle, so one request is taken
// every cycle while the receiver keeps up. The result sits in one output
// register; on a stall it holds and s_ready drops until the beat is taken.
// cfg_wr_en/cfg_wr_data set the capacity in use; zero counts as one, values
// above DEPTH saturate. Write it only while the queue is idle.
// Reset clears the occupancy and the output valid and sets capacity to 16;
// the cell contents are not cleared and are never read while unoccupied.
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire spq_req_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output spq_rsp_t              m_data,
    input  wire logic             cfg_wr_en,
    input  wire logic [CAP_W-1:0] cfg_wr_data
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_eff;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg;
    spq_rsp_t         m_data_reg, rsp_next;

    spq_cmd_t         cmd;
    logic             accept, full, empty;

    logic [DEPTH-1:0]    cell_le;
    logic [DEPTH-1:0]    cell_occ;
    logic [KEY_BITS-1:0] cell_key [DEPTH];
    logic [TAG_BITS-1:0] cell_tag [DEPTH];

    always_comb begin
        if (cap_reg == '0) begin
            cap_eff = CNT_W'(1);
        end else if (32'(cap_reg) > DEPTH) begin
            cap_eff = CNT_W'(DEPTH);
        end else begin
            cap_eff = CNT_W'(cap_reg);
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = count_reg >= cap_eff;
    assign empty   = count_reg == '0;

    assign cmd.insert = accept && (s_data.req_type == REQ_INSERT) && !full;
    assign cmd.remove = accept && (s_data.req_type == REQ_REMOVE) && !empty;
    assign cmd.key    = s_data.entry_key;
    assign cmd.tag    = s_data.entry_tag;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic                left_le;
            logic [KEY_BITS-1:0] left_key, right_key;
            logic [TAG_BITS-1:0] left_tag, right_tag;

            assign cell_occ[gi] = CNT_W'(gi) < count_reg;

            if (gi == 0) begin : g_head
                // Head takes the new entry whenever it does not stay
                assign left_le  = 1'b1;
                assign left_key = cmd.key;
                assign left_tag = cmd.tag;
            end else begin : g_body
                assign left_le  = cell_le[gi-1];
                assign left_key = cell_key[gi-1];
                assign left_tag = cell_tag[gi-1];
            end

            if (gi == DEPTH - 1) begin : g_tail
                assign right_key = cell_key[gi];
                assign right_tag = cell_tag[gi];
            end else begin : g_mid
                assign right_key = cell_key[gi+1];
                assign right_tag = cell_tag[gi+1];
            end

            spq_cell u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .occupied  (cell_occ[gi]),
                .left_le   (left_le),
                .left_key  (left_key),
                .left_tag  (left_tag),
                .right_key (right_key),
                .right_tag (right_tag),
                .le        (cell_le[gi]),
                .key       (cell_key[gi]),
                .tag       (cell_tag[gi])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CNT_W'(1);
        end else if (cmd.remove) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb begin
        rsp_next.status  = ST_DONE;
        rsp_next.out_key = '0;
        rsp_next.out_tag = '0;
        if (s_data.req_type == REQ_INSERT) begin
            if (full) begin
                rsp_next.status = ST_FULL;
            end
        end else if (empty) begin
            rsp_next.status = ST_EMPTY;
        end else begin
            rsp_next.out_key = cell_key[0];
            rsp_next.out_tag = cell_tag[0];
        end
        rsp_next.occupancy = OCC_W'(count_next);
        rsp_next.is_empty  = count_next == '0;
        rsp_next.is_full   = count_next >= cap_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= DEPTH)
        else $error("occupancy beyond depth");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.req_type == REQ_INSERT) && full) |=> $stable(count_reg))
        else $error("rejected insert changed occupancy");

    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (cell_key[0] <= cell_key[1]))
        else $error("head entries out of order");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.is_empty == (m_data_reg.occupancy == '0)))
        else $error("empty flag disagrees with occupancy");

endmodule

`default_nettype wire
